### hdl/mspt_pkg.sv
// shared types and codes for the periodic timer bank
// no dependencies; imported by every module of the block
`default_nettype none

package mspt_pkg;

    localparam int NUM_SLOTS_DEF  = 4;
    localparam int TIME_WIDTH_DEF = 48;
    localparam int NOW_W          = 48;
    localparam int PERIOD_W       = 32;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 4;
    localparam int LIMIT_W        = 4;

    localparam logic [LIMIT_W-1:0] CATCHUP_MAX = 4'd8;

    localparam logic [2:0] REQ_INIT   = 3'd0;
    localparam logic [2:0] REQ_START  = 3'd1;
    localparam logic [2:0] REQ_STOP   = 3'd2;
    localparam logic [2:0] REQ_CHPER  = 3'd3;
    localparam logic [2:0] REQ_DEINIT = 3'd4;
    localparam logic [2:0] REQ_SOFT   = 3'd5;
    localparam logic [2:0] REQ_DRAIN  = 3'd6;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_INVAL = 2'd1;
    localparam logic [1:0] ST_BUSY  = 2'd2;
    localparam logic [1:0] ST_STATE = 2'd3;

    localparam logic [1:0] KIND_RESP = 2'd0;
    localparam logic [1:0] KIND_FIRE = 2'd1;
    localparam logic [1:0] KIND_OVER = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_CATCHUP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REALTIME = 2'd1;

    typedef struct packed {
        logic latch;
        logic exec;
        logic drain_init;
        logic look;
        logic fire;
        logic overrun;
        logic next;
        logic respond;
    } t_dp_cmd;

    typedef struct packed {
        logic is_drain;
        logic due_active;
        logic over_limit;
        logic last_slot;
    } t_dp_stat;

endpackage

`default_nettype wire

### hdl/mspt_datapath.sv
// slot state, shared deadline adder, config registers and result register
// depends on mspt_pkg; driven by mspt_ctrl commands
`default_nettype none

module mspt_datapath import mspt_pkg::*; #(
    parameter int NUM_SLOTS  = NUM_SLOTS_DEF,
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_dp_cmd               i_cmd,
    output t_dp_stat                   o_stat,
    input  wire logic [2:0]            i_req_type,
    input  wire logic [2:0]            i_slot_id,
    input  wire logic [PERIOD_W-1:0]   i_period_value,
    input  wire logic                  i_one_shot,
    input  wire logic                  i_start_at_init,
    input  wire logic [NOW_W-1:0]      i_now_time,
    input  wire logic                  i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                       o_valid,
    output logic [1:0]                 o_status,
    output logic [1:0]                 o_event_kind,
    output logic [2:0]                 o_event_slot,
    output logic                       o_last
);

    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [2:0]    SLOT_CNT  = 3'(NUM_SLOTS);
    localparam logic [SW-1:0] SLOT_LAST = SW'(NUM_SLOTS - 1);

    logic [NUM_SLOTS-1:0]  r_used;
    logic [NUM_SLOTS-1:0]  r_running;
    logic [NUM_SLOTS-1:0]  r_oneshot;
    logic [PERIOD_W-1:0]   r_pending [NUM_SLOTS];
    logic [PERIOD_W-1:0]   r_period [NUM_SLOTS];
    logic [TIME_WIDTH-1:0] r_deadline [NUM_SLOTS];

    logic [LIMIT_W-1:0]    r_limit;
    logic                  r_realtime;

    logic [2:0]            r_req;
    logic [2:0]            r_sid;
    logic [PERIOD_W-1:0]   r_period_in;
    logic                  r_oneshot_in;
    logic                  r_autostart;
    logic [TIME_WIDTH-1:0] r_now;

    logic [SW-1:0]         r_ptr;
    logic [LIMIT_W-1:0]    r_fires;
    logic                  r_due;
    logic [1:0]            r_status;

    logic                  r_o_valid;
    logic [1:0]            r_o_status;
    logic [1:0]            r_o_kind;
    logic [2:0]            r_o_slot;
    logic                  r_o_last;

    logic                  sid_ok;
    logic [SW-1:0]         cur;
    logic                  is_drain;
    logic [1:0]            exec_status;
    logic                  exec_ok;
    logic                  do_adv;
    logic                  use_now;
    logic [PERIOD_W-1:0]   eff_period;
    logic [PERIOD_W-1:0]   b_sel;
    logic [TIME_WIDTH-1:0] a_sel;
    logic [TIME_WIDTH-1:0] sum;
    logic [LIMIT_W-1:0]    lim;

    assign sid_ok   = r_sid < SLOT_CNT;
    assign is_drain = r_req == REQ_DRAIN;
    assign cur      = is_drain ? r_ptr : (sid_ok ? r_sid[SW-1:0] : '0);
    assign lim      = (r_limit > CATCHUP_MAX) ? CATCHUP_MAX : r_limit;

    always_comb begin
        exec_status = ST_OK;
        unique case (r_req)
            REQ_INIT: begin
                if (!sid_ok || r_period_in == '0) exec_status = ST_INVAL;
                else if (r_used[cur])             exec_status = ST_BUSY;
            end
            REQ_START, REQ_STOP: begin
                if (!sid_ok)           exec_status = ST_INVAL;
                else if (!r_used[cur]) exec_status = ST_STATE;
            end
            REQ_CHPER: begin
                if (!sid_ok || r_period_in == '0) exec_status = ST_INVAL;
                else if (!r_used[cur])            exec_status = ST_STATE;
            end
            REQ_DEINIT: begin
                if (!sid_ok) exec_status = ST_INVAL;
            end
            REQ_SOFT: begin
                if (!sid_ok)                               exec_status = ST_INVAL;
                else if (!r_used[cur] || !r_running[cur])  exec_status = ST_STATE;
            end
            REQ_DRAIN: exec_status = ST_OK;
            default:   exec_status = ST_INVAL;
        endcase
    end

    assign exec_ok = i_cmd.exec && (exec_status == ST_OK);
    assign do_adv  = i_cmd.fire || (exec_ok && r_req == REQ_SOFT);

    // shared adder: now or deadline plus a period
    assign eff_period = (r_pending[cur] != '0) ? r_pending[cur] : r_period[cur];
    assign use_now    = i_cmd.overrun ||
                        (i_cmd.exec && (r_req == REQ_INIT || r_req == REQ_START));
    always_comb begin
        if (i_cmd.exec && r_req == REQ_INIT) b_sel = r_period_in;
        else if (use_now)                    b_sel = r_period[cur];
        else                                 b_sel = eff_period;
    end
    assign a_sel = use_now ? r_now : r_deadline[cur];
    assign sum   = a_sel + TIME_WIDTH'(b_sel);

    // control state and flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used     <= '0;
            r_running  <= '0;
            r_oneshot  <= '0;
            for (int i = 0; i < NUM_SLOTS; i++) r_pending[i] <= '0;
            r_limit    <= CATCHUP_MAX;
            r_realtime <= 1'b0;
            r_o_valid  <= 1'b0;
            r_ptr      <= '0;
            r_fires    <= '0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_CATCHUP)  r_limit    <= i_cfg_data[LIMIT_W-1:0];
                if (i_cfg_index == CFG_REALTIME) r_realtime <= i_cfg_data[0];
            end
            r_o_valid <= i_cmd.fire || i_cmd.overrun || i_cmd.respond || do_adv;
            if (i_cmd.drain_init) begin
                r_ptr   <= '0;
                r_fires <= '0;
            end
            if (i_cmd.next) begin
                r_ptr   <= r_ptr + SW'(1);
                r_fires <= '0;
            end
            if (i_cmd.fire) r_fires <= r_fires + LIMIT_W'(1);
            if (exec_ok) begin
                unique case (r_req)
                    REQ_INIT: begin
                        r_used[cur]    <= 1'b1;
                        r_running[cur] <= r_autostart;
                        r_oneshot[cur] <= r_oneshot_in;
                        r_pending[cur] <= '0;
                    end
                    REQ_START:  r_running[cur] <= 1'b1;
                    REQ_STOP:   r_running[cur] <= 1'b0;
                    REQ_CHPER:  r_pending[cur] <= r_period_in;
                    REQ_DEINIT: begin
                        r_used[cur]    <= 1'b0;
                        r_running[cur] <= 1'b0;
                        r_pending[cur] <= '0;
                    end
                    default: ;
                endcase
            end
            if (do_adv) begin
                if (r_oneshot[cur])              r_running[cur] <= 1'b0;
                else if (r_pending[cur] != '0)   r_pending[cur] <= '0;
            end
            if (i_cmd.overrun && !r_realtime) r_running[cur] <= 1'b0;
        end
    end

    // payload: request copy, periods, deadlines, result fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_req        <= i_req_type;
            r_sid        <= i_slot_id;
            r_period_in  <= i_period_value;
            r_oneshot_in <= i_one_shot;
            r_autostart  <= i_start_at_init;
            r_now        <= TIME_WIDTH'(i_now_time);
            r_status     <= ST_OK;
        end
        if (i_cmd.exec) r_status <= exec_status;
        if (exec_ok && r_req == REQ_INIT) begin
            r_period[cur]   <= r_period_in;
            r_deadline[cur] <= sum;
        end
        if (exec_ok && r_req == REQ_START) r_deadline[cur] <= sum;
        if (do_adv && !r_oneshot[cur]) begin
            r_period[cur]   <= eff_period;
            r_deadline[cur] <= sum;
        end
        if (i_cmd.overrun && r_realtime) r_deadline[cur] <= sum;
        if (i_cmd.look) r_due <= r_deadline[r_ptr] <= r_now;

        if (i_cmd.respond) begin
            r_o_status <= r_status;
            r_o_kind   <= KIND_RESP;
            r_o_slot   <= '0;
            r_o_last   <= 1'b1;
        end else begin
            r_o_status <= ST_OK;
            r_o_kind   <= i_cmd.overrun ? KIND_OVER : KIND_FIRE;
            r_o_slot   <= 3'(cur);
            r_o_last   <= 1'b0;
        end
    end

    assign o_stat.is_drain   = is_drain;
    assign o_stat.due_active = r_used[r_ptr] && r_running[r_ptr] && r_due;
    assign o_stat.over_limit = r_fires >= lim;
    assign o_stat.last_slot  = r_ptr == SLOT_LAST;

    assign o_valid      = r_o_valid;
    assign o_status     = r_o_status;
    assign o_event_kind = r_o_kind;
    assign o_event_slot = r_o_slot;
    assign o_last       = r_o_last;

endmodule

`default_nettype wire

### hdl/mspt_ctrl.sv
// request sequencer for the timer bank: execute, drain walk, response
// depends on mspt_pkg; commands mspt_datapath
`default_nettype none

module mspt_ctrl import mspt_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_start,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd,
    output logic          o_busy
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_LOOK = 3'd2;
    localparam logic [2:0] S_ACT  = 3'd3;
    localparam logic [2:0] S_RESP = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_stat.is_drain) begin
                    o_cmd.drain_init = 1'b1;
                    n_state          = S_LOOK;
                end else begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_RESP;
                end
            end
            S_LOOK: begin
                o_cmd.look = 1'b1;
                n_state    = S_ACT;
            end
            S_ACT: begin
                priority if (i_stat.due_active && !i_stat.over_limit) begin
                    o_cmd.fire = 1'b1;
                    n_state    = S_LOOK;
                end else begin
                    o_cmd.overrun = i_stat.due_active;
                    if (i_stat.last_slot) begin
                        n_state = S_RESP;
                    end else begin
                        o_cmd.next = 1'b1;
                        n_state    = S_LOOK;
                    end
                end
            end
            S_RESP: begin
                o_cmd.respond = 1'b1;
                n_state       = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = r_state != S_IDLE;

endmodule

`default_nettype wire

### hdl/multi_slot_periodic_timer_bank_core.sv
// Timer bank with NUM_SLOTS periodic or one-shot slots, advanced by the time stamp carried
// with each request. A request is taken when i_start is high and o_busy low. Control
// requests hold o_busy through the execute and response states and give one response item
// the cycle after; a soft fire gives its fire item in the response state. A drain holds
// o_busy through execute, the slot walk and response and gives its response item the cycle
// after: each slot gets a compare state and a decision state, each fire reuses the one
// shared deadline adder before the slot is compared again, and an overrun item comes out of
// the slot's last decision state. Every item appears on the result ports for exactly one
// cycle with o_valid high and cannot be held off; the response item, with o_last set, ends
// each request. Config writes on i_cfg_* are always ready and are meant for idle periods.
// depends on mspt_pkg, mspt_ctrl, mspt_datapath
`default_nettype none

module multi_slot_periodic_timer_bank_core import mspt_pkg::*; #(
    parameter int NUM_SLOTS  = NUM_SLOTS_DEF,
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    output logic                       o_busy,
    input  wire logic [2:0]            i_req_type,
    input  wire logic [2:0]            i_slot_id,
    input  wire logic [PERIOD_W-1:0]   i_period_value,
    input  wire logic                  i_one_shot,
    input  wire logic                  i_start_at_init,
    input  wire logic [NOW_W-1:0]      i_now_time,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                       o_valid,
    output logic [1:0]                 o_status,
    output logic [1:0]                 o_event_kind,
    output logic [2:0]                 o_event_slot,
    output logic                       o_last
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    mspt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    mspt_datapath #(
        .NUM_SLOTS  (NUM_SLOTS),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_req_type      (i_req_type),
        .i_slot_id       (i_slot_id),
        .i_period_value  (i_period_value),
        .i_one_shot      (i_one_shot),
        .i_start_at_init (i_start_at_init),
        .i_now_time      (i_now_time),
        .i_cfg_valid     (i_cfg_valid & o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_event_kind    (o_event_kind),
        .o_event_slot    (o_event_slot),
        .o_last          (o_last)
    );

    a_resp_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> !o_busy)
        else $error("response item while request still in progress");

    a_event_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> o_busy)
        else $error("event item outside a request");

    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last == (o_event_kind == KIND_RESP)))
        else $error("last flag does not match response item");

    a_event_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_event_kind != KIND_RESP |-> o_status == ST_OK)
        else $error("event item with nonzero status");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy |=> o_busy && !o_valid)
        else $error("accepted request did not raise busy");

endmodule

`default_nettype wire
